@@ design/uart_register_access_host_unit_macros.svh @@
// ----------------------------------------------------------------------------
// UART register access host: assertion macros
// Concurrent assertion helpers for the register access host design.
// ----------------------------------------------------------------------------
`ifndef UART_REGISTER_ACCESS_HOST_UNIT_MACROS_SVH
`define UART_REGISTER_ACCESS_HOST_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UARH_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("%m: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define UARH_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("%m: next-cycle implication failed");

`endif

@@ design/uarh_pkg.sv @@
// ----------------------------------------------------------------------------
// UART register access host: package
// Types, protocol byte codes and helper functions shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package uarh_pkg;

    localparam int DEFAULT_MAX_READ_LEN = 128;

    localparam logic [3:0]  RESET_RETRY_LIMIT   = 4'd3;
    localparam logic [15:0] RESET_TIMEOUT_TICKS = 16'd20;

    localparam logic [1:0] CFG_RETRY_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;

    localparam logic [7:0] SYNC_BYTE      = 8'hAA;
    localparam logic [7:0] CMD_WRITE      = 8'h00;
    localparam logic [7:0] CMD_READ       = 8'h01;
    localparam logic [7:0] WRITE_LENGTH   = 8'h01;
    localparam logic [7:0] RESP_READ_OK   = 8'hBB;
    localparam logic [7:0] RESP_ERROR     = 8'hEE;
    localparam logic [7:0] WRITE_OK       = 8'h01;
    localparam logic [7:0] NO_STATUS      = 8'h00;
    localparam logic [7:0] ST_READ_FAIL   = 8'h02;
    localparam logic [7:0] ST_WRITE_FAIL  = 8'h03;
    localparam logic [7:0] ST_BAD_LENGTH  = 8'h06;
    localparam logic [7:0] ST_OVERRUN     = 8'h07;
    localparam logic [7:0] ST_BUS_BUSY    = 8'h0A;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RX    = 2'd2,
        OP_TICK  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_CMD    = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_FINISH = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_SECOND = 2'd2,
        PH_STREAM = 2'd3
    } phase_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] reg_addr;
        logic [7:0] read_length;
        logic [7:0] write_value;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_value;
        logic [7:0] status_byte;
        logic       timed_out;
        logic [3:0] attempts_used;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic       cmd;
        logic       is_write;
        logic [7:0] reg_addr;
        logic [7:0] length;
        logic [7:0] value;
        logic       data;
        logic [7:0] data_byte;
        logic       fin;
        logic [7:0] fin_status;
        logic       fin_timeout;
        logic [3:0] fin_attempts;
    } batch_t;

    function automatic logic is_retryable(input logic [7:0] status, input logic wr);
        logic common;
        common = (status == ST_BAD_LENGTH) || (status == ST_OVERRUN) ||
                 (status == ST_BUS_BUSY);
        return common || (wr ? (status == ST_WRITE_FAIL) : (status == ST_READ_FAIL));
    endfunction

endpackage

`default_nettype wire

@@ design/uart_register_access_host_unit.sv @@
// ----------------------------------------------------------------------------
// UART register access host: top level
// Builds command bytes for register reads and writes, decodes the responses,
// retries on failure statuses and timeouts, and streams read data.
//
//   Channel   Ports                      Moves
//   input     s_valid s_ready s_data     start, received byte or tick
//   result    m_valid m_ready m_data     command byte, data byte or finish
//   config    cfg_valid cfg_ready ...    retry limit and timeout registers
//
// Each transaction is registered, then decoded combinationally into up to five
// results, which leave one per cycle while the result channel accepts them.
// The next item is decoded in the cycle the last result of the previous one leaves.
// Reset is synchronous and active low; it restores the state and configuration registers and goes idle.
// A stalled result channel holds the result and, once the input register fills,
// back-pressures the input channel.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_register_access_host_unit #(
    parameter int MAX_READ_LEN = uarh_pkg::DEFAULT_MAX_READ_LEN
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire uarh_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output uarh_pkg::out_item_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import uarh_pkg::*;

    `include "uart_register_access_host_unit_macros.svh"

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic [3:0]  retry_limit_reg;
    logic [15:0] timeout_ticks_reg;
    logic        emitter_free;
    logic        consume;
    logic        load;
    batch_t      batch;

    assign consume   = in_valid_reg && emitter_free;
    assign load      = consume && (batch.cmd || batch.data || batch.fin);
    assign s_ready   = !in_valid_reg || consume;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_limit_reg   <= RESET_RETRY_LIMIT;
            timeout_ticks_reg <= RESET_TIMEOUT_TICKS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_RETRY_LIMIT:   retry_limit_reg   <= cfg_data[3:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    uarh_core #(
        .MAX_READ_LEN(MAX_READ_LEN)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item          (in_item_reg),
        .item_take     (consume),
        .retry_limit   (retry_limit_reg),
        .timeout_ticks (timeout_ticks_reg),
        .batch         (batch)
    );

    uarh_emitter u_emitter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .batch   (batch),
        .load    (load),
        .free    (emitter_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `UARH_ASSERT_IMPLIES(a_finish_is_last, aclk, aresetn, m_valid && m_data.kind == KIND_FINISH, m_data.last)
    `UARH_ASSERT_IMPLIES(a_finish_has_attempt, aclk, aresetn, m_valid && m_data.kind == KIND_FINISH, m_data.attempts_used != 4'd0)
    `UARH_ASSERT_NEXT(a_item_held, aclk, aresetn, in_valid_reg && !emitter_free, in_valid_reg && $stable(in_item_reg))

endmodule

`default_nettype wire

@@ design/uarh_core.sv @@
// ----------------------------------------------------------------------------
// UART register access host: protocol core
// Holds the transfer state and turns one item into a batch of results.
// ----------------------------------------------------------------------------
`default_nettype none

module uarh_core #(
    parameter int MAX_READ_LEN = uarh_pkg::DEFAULT_MAX_READ_LEN
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire uarh_pkg::in_item_t item,
    input  wire logic              item_take,
    input  wire logic [3:0]        retry_limit,
    input  wire logic [15:0]       timeout_ticks,
    output uarh_pkg::batch_t       batch
);
    import uarh_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        is_write_reg, is_write_next;
    logic [7:0]  saved_reg_reg, saved_reg_next;
    logic [7:0]  saved_length_reg, saved_length_next;
    logic [7:0]  saved_value_reg, saved_value_next;
    logic [3:0]  attempt_count_reg, attempt_count_next;
    logic [7:0]  rx_count_reg, rx_count_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [7:0]  header_byte_reg, header_byte_next;
    logic [7:0]  last_status_reg, last_status_next;

    logic        can_retry;
    logic [7:0]  clamped_length;
    logic [7:0]  rx_count_inc;
    logic [15:0] tick_count_inc;
    logic        send;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            is_write_reg      <= 1'b0;
            saved_reg_reg     <= '0;
            saved_length_reg  <= '0;
            saved_value_reg   <= '0;
            attempt_count_reg <= '0;
            rx_count_reg      <= '0;
            tick_count_reg    <= '0;
            header_byte_reg   <= '0;
            last_status_reg   <= '0;
        end else if (item_take) begin
            phase_reg         <= phase_next;
            is_write_reg      <= is_write_next;
            saved_reg_reg     <= saved_reg_next;
            saved_length_reg  <= saved_length_next;
            saved_value_reg   <= saved_value_next;
            attempt_count_reg <= attempt_count_next;
            rx_count_reg      <= rx_count_next;
            tick_count_reg    <= tick_count_next;
            header_byte_reg   <= header_byte_next;
            last_status_reg   <= last_status_next;
        end
    end

    always_comb begin
        phase_next         = phase_reg;
        is_write_next      = is_write_reg;
        saved_reg_next     = saved_reg_reg;
        saved_length_next  = saved_length_reg;
        saved_value_next   = saved_value_reg;
        attempt_count_next = attempt_count_reg;
        rx_count_next      = rx_count_reg;
        tick_count_next    = tick_count_reg;
        header_byte_next   = header_byte_reg;
        last_status_next   = last_status_reg;
        batch              = '0;
        send               = 1'b0;

        can_retry = attempt_count_reg < retry_limit;

        clamped_length = item.read_length;
        if (clamped_length == 8'd0) begin
            clamped_length = 8'd1;
        end
        if (clamped_length > 8'(MAX_READ_LEN)) begin
            clamped_length = 8'(MAX_READ_LEN);
        end

        rx_count_inc   = rx_count_reg + 8'd1;
        tick_count_inc = (tick_count_reg != 16'hFFFF) ? tick_count_reg + 16'd1
                                                      : tick_count_reg;

        unique case (item.opcode) inside
            OP_READ, OP_WRITE: begin
                if (phase_reg == PH_IDLE) begin
                    is_write_next      = (item.opcode == OP_WRITE);
                    saved_reg_next     = item.reg_addr;
                    saved_value_next   = item.write_value;
                    saved_length_next  = clamped_length;
                    attempt_count_next = 4'd1;
                    last_status_next   = NO_STATUS;
                    send               = 1'b1;
                end
            end
            OP_RX: begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        header_byte_next = item.rx_byte;
                        if (is_write_reg || item.rx_byte == RESP_READ_OK ||
                            item.rx_byte == RESP_ERROR) begin
                            phase_next = PH_SECOND;
                        end else begin
                            phase_next        = PH_IDLE;
                            batch.fin         = 1'b1;
                            batch.fin_status  = NO_STATUS;
                        end
                    end
                    PH_SECOND: begin
                        if (!is_write_reg && header_byte_reg == RESP_READ_OK) begin
                            phase_next    = PH_STREAM;
                            rx_count_next = '0;
                        end else begin
                            last_status_next = item.rx_byte;
                            if (!(is_write_reg && item.rx_byte == WRITE_OK) &&
                                is_retryable(item.rx_byte, is_write_reg) && can_retry) begin
                                attempt_count_next = attempt_count_reg + 4'd1;
                                send               = 1'b1;
                            end else begin
                                phase_next       = PH_IDLE;
                                batch.fin        = 1'b1;
                                batch.fin_status = item.rx_byte;
                            end
                        end
                    end
                    PH_STREAM: begin
                        batch.data      = 1'b1;
                        batch.data_byte = item.rx_byte;
                        rx_count_next   = rx_count_inc;
                        if (rx_count_inc >= saved_length_reg) begin
                            last_status_next = RESP_READ_OK;
                            phase_next       = PH_IDLE;
                            batch.fin        = 1'b1;
                            batch.fin_status = RESP_READ_OK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_TICK: begin
                if (phase_reg != PH_IDLE) begin
                    tick_count_next = tick_count_inc;
                    if (tick_count_inc >= timeout_ticks) begin
                        if (phase_reg == PH_HEADER && can_retry) begin
                            attempt_count_next = attempt_count_reg + 4'd1;
                            send               = 1'b1;
                        end else begin
                            phase_next        = PH_IDLE;
                            batch.fin         = 1'b1;
                            batch.fin_status  = last_status_reg;
                            batch.fin_timeout = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (send) begin
            phase_next       = PH_HEADER;
            rx_count_next    = '0;
            tick_count_next  = '0;
            header_byte_next = '0;
            batch.cmd        = 1'b1;
        end

        batch.is_write     = is_write_next;
        batch.reg_addr     = saved_reg_next;
        batch.length       = saved_length_next;
        batch.value        = saved_value_next;
        batch.fin_attempts = attempt_count_next;
    end

endmodule

`default_nettype wire

@@ design/uarh_emitter.sv @@
// ----------------------------------------------------------------------------
// UART register access host: result emitter
// Holds one batch and presents its results one per cycle on the result channel while m_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module uarh_emitter (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire uarh_pkg::batch_t batch,
    input  wire logic             load,
    output logic                  free,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output uarh_pkg::out_item_t   m_data
);
    import uarh_pkg::*;

    logic       busy_reg;
    batch_t     batch_reg;
    logic [2:0] beat_reg;
    logic [2:0] beat_count;
    logic       last_beat;

    always_comb begin
        if (batch_reg.cmd) begin
            beat_count = batch_reg.is_write ? 3'd5 : 3'd4;
        end else begin
            beat_count = {2'b00, batch_reg.data} + {2'b00, batch_reg.fin};
        end
        last_beat = (beat_reg == beat_count - 3'd1);
        m_valid   = busy_reg;
        free      = !busy_reg || (m_ready && last_beat);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            beat_reg <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            beat_reg <= '0;
        end else if (busy_reg && m_ready) begin
            if (last_beat) begin
                busy_reg <= 1'b0;
            end else begin
                beat_reg <= beat_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            batch_reg <= batch;
        end
    end

    always_comb begin
        m_data      = '0;
        m_data.last = last_beat;
        if (batch_reg.cmd) begin
            m_data.kind = KIND_CMD;
            case (beat_reg)
                3'd0:    m_data.byte_value = SYNC_BYTE;
                3'd1:    m_data.byte_value = batch_reg.is_write ? CMD_WRITE : CMD_READ;
                3'd2:    m_data.byte_value = batch_reg.reg_addr;
                3'd3:    m_data.byte_value = batch_reg.is_write ? WRITE_LENGTH
                                                                : batch_reg.length;
                default: m_data.byte_value = batch_reg.value;
            endcase
        end else if (batch_reg.data && beat_reg == 3'd0) begin
            m_data.kind       = KIND_DATA;
            m_data.byte_value = batch_reg.data_byte;
        end else begin
            m_data.kind          = KIND_FINISH;
            m_data.status_byte   = batch_reg.fin_status;
            m_data.timed_out     = batch_reg.fin_timeout;
            m_data.attempts_used = batch_reg.fin_attempts;
        end
    end

endmodule

`default_nettype wire
